[rtl/ihl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ihl_pkg;

   // Fixed field widths of the item and result channels
   localparam int unsigned IDX_WIDTH   = 10;
   localparam int unsigned LEN_WIDTH   = 11;
   localparam int unsigned VALUE_WIDTH = 32;

   // Default number of table entries held
   localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

   // Item kind codes
   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_LOCATE = 1'b1;

   // Search sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_EDGE_LOW,
      ST_EDGE_HIGH,
      ST_HINT,
      ST_HUNT_UP,
      ST_HUNT_DOWN,
      ST_BISECT,
      ST_DONE
   } seq_state_type;

   // Turn a signed Q16.16 value into an offset-binary key: unsigned order of
   // keys equals signed order of values
   function automatic logic [VALUE_WIDTH-1:0] key_of(input logic [VALUE_WIDTH-1:0] v);
      key_of = {~v[VALUE_WIDTH-1], v[VALUE_WIDTH-2:0]};
   endfunction

endpackage

`default_nettype wire

[rtl/interval_hunt_locator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_ready     kind, entry_index, entry_value, query_value
// rsp_      out        rsp_valid / rsp_ready     interval_index
// csr_      in         csr_write_enable          table_length (csr_write_data)
//
// A load item gives no result. A locate item does its hunt reads and then its
// bisection reads, with at most one table read and one compare per cycle,
// through the single read port of the table memory.
// Synchronous reset clears the sequencer, the hint, the output valid and sets
// the length to one; table contents are undefined until loaded.
// A result held on a stalled rsp_ready does not block new items; a finished
// search waits in its last state until the output register is free.

module interval_hunt_locator_unit
   import ihl_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic        [IDX_WIDTH-1:0]   req_entry_index,
   input  wire logic signed [VALUE_WIDTH-1:0] req_entry_value,
   input  wire logic signed [VALUE_WIDTH-1:0] req_query_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [LEN_WIDTH-1:0]   rsp_interval_index,
   input  wire logic                          csr_write_enable,
   input  wire logic        [LEN_WIDTH-1:0]   csr_write_data
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned LW = $clog2(TABLE_DEPTH + 1);

   // Registers
   seq_state_type          state_ff, state_in;
   logic [LEN_WIDTH-1:0]   len_ff;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [VALUE_WIDTH-1:0] t_first_ff, t_first_in;
   logic [VALUE_WIDTH-1:0] t_last_ff, t_last_in;
   logic                   asc_ff, asc_in;
   logic [LW-1:0]          n_ff, n_in;
   logic [LW-1:0]          lo_ff, lo_in;
   logic [LW-1:0]          hi_ff, hi_in;
   logic [LW:0]            step_ff, step_in;
   logic [AW-1:0]          hint_ff, hint_in;
   logic [LW-1:0]          res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [LEN_WIDTH-1:0]   rsp_index_ff, rsp_index_in;

   // Memory port
   logic                   wr_en;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   // Shared comparator and search arithmetic
   logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
   logic                   cmp_ge;
   logic                   go_search;
   logic [LW-1:0]          n_clamp;
   logic [LW:0]            step_dbl;
   logic [LW+1:0]          up_sum;
   logic [LW-1:0]          span;
   logic [LW:0]            mid_sum;
   logic [LW-1:0]          mid_next;
   logic [LW:0]            mid_cur_sum;
   logic [LW-1:0]          mid_cur;
   logic [LW-1:0]          hint_ext;

   ihl_table_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ihl_table_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (key_of(req_entry_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Clamp the programmed length into 1..TABLE_DEPTH
   always_comb begin
      if (len_ff == '0) begin
         n_clamp = LW'(1);
      end else if (32'(len_ff) > 32'(TABLE_DEPTH)) begin
         n_clamp = LW'(TABLE_DEPTH);
      end else begin
         n_clamp = LW'(len_ff);
      end
   end

   assign cmp_ge      = (cmp_a >= cmp_b);
   assign hint_ext    = LW'(hint_ff);
   assign step_dbl    = step_ff << 1;
   assign mid_cur_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_cur     = mid_cur_sum[LW:1];

   // Sequencer: next state, search bounds and memory address
   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      t_first_in   = t_first_ff;
      t_last_in    = t_last_ff;
      asc_in       = asc_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      hint_in      = hint_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      wr_en        = 1'b0;
      rd_addr      = '0;
      cmp_a        = key_ff;
      cmp_b        = rd_data;
      go_search    = 1'b0;
      up_sum       = '0;
      span         = '0;
      mid_sum      = '0;
      mid_next     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOAD) begin
                  wr_en   = (32'(req_entry_index) < 32'(TABLE_DEPTH));
                  hint_in = '0;
               end else begin
                  key_in = key_of(req_query_value);
                  n_in   = n_clamp;
                  if (n_clamp == LW'(1)) begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FIRST;
                  end
               end
            end
         end
         ST_FIRST: begin
            t_first_in = rd_data;
            rd_addr    = AW'(n_ff - LW'(1));
            state_in   = ST_LAST;
         end
         ST_LAST: begin
            // direction: ascending when last >= first
            t_last_in = rd_data;
            cmp_a     = rd_data;
            cmp_b     = t_first_ff;
            asc_in    = cmp_ge;
            state_in  = ST_EDGE_LOW;
         end
         ST_EDGE_LOW: begin
            cmp_a = t_first_ff;
            cmp_b = key_ff;
            if (cmp_ge == asc_ff) begin
               res_in   = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_EDGE_HIGH;
            end
         end
         ST_EDGE_HIGH: begin
            cmp_a = t_last_ff;
            cmp_b = key_ff;
            if (cmp_ge != asc_ff) begin
               res_in   = n_ff;
               state_in = ST_DONE;
            end else if ((hint_ff != '0) && (hint_ext < n_ff)) begin
               lo_in    = hint_ext;
               rd_addr  = hint_ff;
               state_in = ST_HINT;
            end else begin
               lo_in     = '0;
               hi_in     = n_ff;
               go_search = 1'b1;
            end
         end
         ST_HINT: begin
            if (cmp_ge == asc_ff) begin
               if (lo_ff >= n_ff - LW'(1)) begin
                  res_in   = lo_ff;
                  state_in = ST_DONE;
               end else begin
                  hi_in    = lo_ff + LW'(1);
                  step_in  = (LW+1)'(1);
                  rd_addr  = AW'(lo_ff + LW'(1));
                  state_in = ST_HUNT_UP;
               end
            end else begin
               hi_in    = lo_ff;
               lo_in    = lo_ff - LW'(1);
               step_in  = (LW+1)'(1);
               rd_addr  = AW'(lo_ff - LW'(1));
               state_in = ST_HUNT_DOWN;
            end
         end
         ST_HUNT_UP: begin
            // advance upwards with doubling steps while still below the value
            if (cmp_ge == asc_ff) begin
               lo_in   = hi_ff;
               step_in = step_dbl;
               up_sum  = (LW+2)'(hi_ff) + (LW+2)'(step_dbl);
               if (up_sum >= (LW+2)'(n_ff)) begin
                  hi_in     = n_ff;
                  go_search = 1'b1;
               end else begin
                  hi_in   = LW'(up_sum);
                  rd_addr = AW'(up_sum);
               end
            end else begin
               go_search = 1'b1;
            end
         end
         ST_HUNT_DOWN: begin
            // step downwards with doubling steps while still above the value
            if (cmp_ge != asc_ff) begin
               hi_in   = lo_ff;
               step_in = step_dbl;
               if (step_dbl >= (LW+1)'(lo_ff)) begin
                  lo_in     = '0;
                  go_search = 1'b1;
               end else begin
                  lo_in   = LW'((LW+1)'(lo_ff) - step_dbl);
                  rd_addr = AW'((LW+1)'(lo_ff) - step_dbl);
               end
            end else begin
               go_search = 1'b1;
            end
         end
         ST_BISECT: begin
            // ascending: x > t[mid]; descending: x < t[mid]
            cmp_a = asc_ff ? rd_data : key_ff;
            cmp_b = asc_ff ? key_ff : rd_data;
            if (!cmp_ge) begin
               lo_in = mid_cur;
            end else begin
               hi_in = mid_cur;
            end
            go_search = 1'b1;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = LEN_WIDTH'(res_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Bisect the bracket, or finish once it is one entry wide
      if (go_search) begin
         span     = hi_in - lo_in;
         mid_sum  = {1'b0, lo_in} + {1'b0, hi_in};
         mid_next = mid_sum[LW:1];
         if (span > LW'(1)) begin
            rd_addr  = AW'(mid_next);
            state_in = ST_BISECT;
         end else begin
            res_in   = hi_in;
            hint_in  = AW'(lo_in);
            state_in = ST_DONE;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_WIDTH'(1);
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            len_ff <= csr_write_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      t_first_ff   <= t_first_in;
      t_last_ff    <= t_last_in;
      asc_ff       <= asc_in;
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      step_ff      <= step_in;
      res_ff       <= res_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_interval_index = rsp_index_ff;

endmodule

`default_nettype wire

[rtl/ihl_table_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module ihl_table_ram
   import ihl_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_TABLE_DEPTH,
   parameter int unsigned AW    = $clog2(DEFAULT_TABLE_DEPTH)
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [VALUE_WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output logic      [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry, read data registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ihl_port_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ihl_port_checker
   import ihl_pkg::*;
(
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        req_kind,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [LEN_WIDTH-1:0]        rsp_interval_index,
   input wire logic                        csr_write_enable,
   input wire logic [LEN_WIDTH-1:0]        csr_write_data
);

   logic [LEN_WIDTH-1:0] len_mirror_ff;

   // Track the programmed length as seen on the port
   always_ff @(posedge clock) begin
      if (reset) begin
         len_mirror_ff <= LEN_WIDTH'(1);
      end else if (csr_write_enable) begin
         len_mirror_ff <= csr_write_data;
      end
   end

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_interval_index))
      else $error("result changed while stalled");

   // A locate item keeps the block busy for the following cycle
   a_locate_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_LOCATE) |=> !req_ready)
      else $error("block ready straight after a locate item");

   // A load item leaves the block ready
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_LOAD) |=> req_ready)
      else $error("block busy after a load item");

   // Index never beyond the length, and zero for a one-entry table
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_interval_index == '0) ||
                    ((len_mirror_ff > LEN_WIDTH'(1)) &&
                     (rsp_interval_index <= len_mirror_ff)))
      else $error("interval index out of range");

endmodule

bind interval_hunt_locator_unit ihl_port_checker u_ihl_port_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_kind           (req_kind),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_interval_index (rsp_interval_index),
   .csr_write_enable   (csr_write_enable),
   .csr_write_data     (csr_write_data)
);

`default_nettype wire
